// ----- src/rbot_pkg.sv -----
// shared constants, types and trig helpers for the rotated box overlap test
package rbot_pkg;

    localparam int COORD_BITS = 16;
    localparam int ANG_BITS   = 14;
    localparam int TAB_BITS   = 12;
    localparam int TAB_LEN    = (1 << TAB_BITS) + 1;
    localparam int IDX_BITS   = TAB_BITS + 1;
    localparam int TRIG_BITS  = 16;
    localparam int QUARTER    = 5760;
    localparam int EDGES      = 4;
    localparam int STAR_TESTS = 3;
    localparam int STAR_MIN   = 6;
    localparam int IN_BITS    = 160;
    localparam int OUT_BITS   = 8;

    // point, difference and product widths
    localparam int MW = COORD_BITS + 18;
    localparam int PW = COORD_BITS + 18;
    localparam int DW = PW + 1;
    localparam int XW = 2 * DW;

    localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
    localparam logic [18:0] RECIP_45    = 19'd372828;

    // reciprocals for the taylor divisors, exact on the operand ranges of the table build
    localparam logic [31:0] RECIP_3  = 32'd2863311531;
    localparam logic [31:0] RECIP_5  = 32'd3435973837;
    localparam logic [31:0] RECIP_21 = 32'd3272356036;
    localparam logic [31:0] RECIP_9  = 32'd954437177;
    localparam logic [31:0] RECIP_55 = 32'd2498890064;
    localparam logic [31:0] RECIP_39 = 32'd3524075731;

    // table build steps within one entry
    localparam logic [3:0] FILL_X    = 4'd0;
    localparam logic [3:0] FILL_X2   = 4'd1;
    localparam logic [3:0] FILL_LAST = 4'd14;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_A_IN_B = 2'd1,
        CAUSE_B_IN_A = 2'd2,
        CAUSE_STAR = 2'd3
    } t_cause;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic                neg;
    } t_trig_ref;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
    } t_pt;

    // quarter-wave index and sign for an angle in 1/64 degree
    function automatic t_trig_ref trig_ref(input logic [ANG_BITS:0] ang);
        t_trig_ref     res;
        logic [1:0]    q;
        logic [12:0]   r;
        logic [17:0]   t;
        logic [36:0]   m;
        logic [IDX_BITS-1:0] idx;
        if (ang < 15'(QUARTER)) begin
            q = 2'd0;
            r = 13'(ang);
        end else if (ang < 15'(2 * QUARTER)) begin
            q = 2'd1;
            r = 13'(ang - 15'(QUARTER));
        end else if (ang < 15'(3 * QUARTER)) begin
            q = 2'd2;
            r = 13'(ang - 15'(2 * QUARTER));
        end else begin
            q = 2'd3;
            r = 13'(ang - 15'(3 * QUARTER));
        end
        // (r * 4096 + 2880) / 5760 == (r * 32 + 22) / 45
        t = {r, 5'd0} + 18'd22;
        m = 37'(t) * 37'(RECIP_45);
        idx = IDX_BITS'(m >> 24);
        if (idx > IDX_BITS'(1 << TAB_BITS))
            idx = IDX_BITS'(1 << TAB_BITS);
        if (q[0])
            idx = IDX_BITS'(1 << TAB_BITS) - idx;
        res.idx = idx;
        res.neg = q[1];
        return res;
    endfunction

endpackage

// ----- src/rotated_box_overlap_test_core.sv -----
// rotated box overlap test: seven-stage pipeline, one box pair per cycle
// an accepted input beat passes the index, table read, axes, corner, difference, cross product and result registers
// throughput: one beat per cycle; the whole pipe holds while the output beat waits
// reset: synchronous active low; afterwards the sine table is built
// (4097 entries) with input ready low, then beats are taken
// four copies of the sine table give the four lookups of one beat per cycle
module rotated_box_overlap_test_core import rbot_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // first_center_x, first_center_y, first_minor_half, first_major_half, first_angle,
    // second_center_x, second_center_y, second_minor_half, second_major_half,
    // second_angle, zero pad
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // overlap, cause[1:0], zero pad
    output logic [OUT_BITS-1:0] m_axis_tdata
);

    logic                en;
    logic [7:1]          r_vld;
    logic [IDX_BITS-1:0] r_fill_cnt;
    logic [3:0]          r_fill_step;
    logic                r_fill_done;

    // table build: taylor series in Q2.30 on one shared 32x32 multiplier
    logic [31:0]         r_fx, r_fx2, r_fterm, r_fprod;
    logic signed [34:0]  r_fsum;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [31:0]         div_q;
    logic signed [34:0]  fill_sum;

    // per-box fields
    logic [COORD_BITS-1:0] in_cx [2];
    logic [COORD_BITS-1:0] in_cy [2];
    logic [COORD_BITS-1:0] in_dx [2];
    logic [COORD_BITS-1:0] in_dy [2];
    logic [ANG_BITS-1:0]   in_an [2];

    assign in_cx[0] = s_axis_tdata[15:0];
    assign in_cy[0] = s_axis_tdata[31:16];
    assign in_dx[0] = s_axis_tdata[47:32];
    assign in_dy[0] = s_axis_tdata[63:48];
    assign in_an[0] = s_axis_tdata[77:64];
    assign in_cx[1] = s_axis_tdata[93:78];
    assign in_cy[1] = s_axis_tdata[109:94];
    assign in_dx[1] = s_axis_tdata[125:110];
    assign in_dy[1] = s_axis_tdata[141:126];
    assign in_an[1] = s_axis_tdata[155:142];

    assign en            = !r_vld[7] || m_axis_tready;
    assign s_axis_tready = en && r_fill_done;
    assign m_axis_tvalid = r_vld[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_fill_cnt  <= '0;
            r_fill_step <= FILL_X;
            r_fill_done <= 1'b0;
        end else begin
            if (!r_fill_done) begin
                if (r_fill_step == FILL_LAST) begin
                    r_fill_step <= FILL_X;
                    if (r_fill_cnt == IDX_BITS'(TAB_LEN - 1))
                        r_fill_done <= 1'b1;
                    else
                        r_fill_cnt <= r_fill_cnt + 1'b1;
                end else begin
                    r_fill_step <= r_fill_step + 4'd1;
                end
            end
            if (en)
                r_vld <= {r_vld[6:1], s_axis_tvalid && s_axis_tready};
        end
    end

    // multiplier operands: x, x squared, term products, then divides by 2k(2k+1)
    always_comb begin
        mul_a = r_fterm;
        mul_b = r_fx2;
        if (r_fill_step == FILL_X) begin
            mul_a = 32'(r_fill_cnt);
            mul_b = PI_HALF_Q30;
        end else if (r_fill_step == FILL_X2) begin
            mul_a = r_fx;
            mul_b = r_fx;
        end else if (r_fill_step[0]) begin
            // power-of-two part as a shift, odd part by reciprocal
            case (r_fill_step[3:1])
                3'd1: begin
                    mul_a = r_fprod >> 1;
                    mul_b = RECIP_3;
                end
                3'd2: begin
                    mul_a = r_fprod >> 2;
                    mul_b = RECIP_5;
                end
                3'd3: begin
                    mul_a = r_fprod >> 1;
                    mul_b = RECIP_21;
                end
                3'd4: begin
                    mul_a = r_fprod >> 3;
                    mul_b = RECIP_9;
                end
                3'd5: begin
                    mul_a = r_fprod >> 1;
                    mul_b = RECIP_55;
                end
                3'd6: begin
                    mul_a = r_fprod >> 2;
                    mul_b = RECIP_39;
                end
                default: begin
                    mul_a = r_fprod;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        case (r_fill_step[3:1])
            3'd1:    div_q = 32'(mul_p >> 33);
            3'd2:    div_q = 32'(mul_p >> 34);
            3'd3:    div_q = 32'(mul_p >> 36);
            3'd4:    div_q = 32'(mul_p >> 33);
            3'd5:    div_q = 32'(mul_p >> 37);
            3'd6:    div_q = 32'(mul_p >> 37);
            default: div_q = 32'(mul_p >> 32);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!r_fill_done) begin
            if (r_fill_step == FILL_X) begin
                r_fx <= 32'(mul_p >> TAB_BITS);
            end else if (r_fill_step == FILL_X2) begin
                r_fx2   <= 32'(mul_p >> 30);
                r_fterm <= r_fx;
                r_fsum  <= signed'({3'd0, r_fx});
            end else if (r_fill_step != FILL_LAST) begin
                if (!r_fill_step[0]) begin
                    r_fprod <= 32'(mul_p >> 30);
                end else begin
                    r_fterm <= div_q;
                    // odd taylor terms subtract
                    if (r_fill_step[1])
                        r_fsum <= r_fsum - signed'({3'd0, div_q});
                    else
                        r_fsum <= r_fsum + signed'({3'd0, div_q});
                end
            end
        end
    end

    always_comb begin
        if (r_fsum[34])
            fill_sum = '0;
        else if (r_fsum > 35'sd1073741824)
            fill_sum = 35'sd1073741824;
        else
            fill_sum = r_fsum;
    end

    // sine table copies: 0/1 sin/cos of box A, 2/3 of box B
    logic [TRIG_BITS-1:0] mem0 [TAB_LEN];
    logic [TRIG_BITS-1:0] mem1 [TAB_LEN];
    logic [TRIG_BITS-1:0] mem2 [TAB_LEN];
    logic [TRIG_BITS-1:0] mem3 [TAB_LEN];
    logic [TRIG_BITS-1:0] fill_val;

    assign fill_val = TRIG_BITS'((fill_sum + 35'sd16384) >>> 15);

    always_ff @(posedge i_clk) begin
        if (!r_fill_done && r_fill_step == FILL_LAST) begin
            mem0[r_fill_cnt] <= fill_val;
            mem1[r_fill_cnt] <= fill_val;
            mem2[r_fill_cnt] <= fill_val;
            mem3[r_fill_cnt] <= fill_val;
        end
    end

    // stage 1: table index and sign
    t_trig_ref             r_s1_sin [2];
    t_trig_ref             r_s1_cos [2];
    logic [COORD_BITS-1:0] r_s1_cx [2], r_s1_cy [2], r_s1_dx [2], r_s1_dy [2];
    // stage 2: table read
    logic [TRIG_BITS-1:0]  r_s2_sin [2];
    logic [TRIG_BITS-1:0]  r_s2_cos [2];
    logic                  r_s2_sneg [2], r_s2_cneg [2];
    logic [COORD_BITS-1:0] r_s2_cx [2], r_s2_cy [2], r_s2_dx [2], r_s2_dy [2];
    // stage 3: scaled axes
    logic signed [MW-1:0]  r_s3_sdy [2], r_s3_cdy [2], r_s3_cdx [2], r_s3_sdx [2];
    logic [COORD_BITS-1:0] r_s3_cx [2], r_s3_cy [2];
    // stage 4: corners
    t_pt                   r_s4_p [2][EDGES];
    // stage 5: edge vectors and corner offsets
    logic signed [DW-1:0]  r_s5_ex [2][EDGES];
    logic signed [DW-1:0]  r_s5_ey [2][EDGES];
    logic signed [DW-1:0]  r_s5_qx [2][EDGES][EDGES];
    logic signed [DW-1:0]  r_s5_qy [2][EDGES][EDGES];
    // stage 6: cross product halves
    logic signed [XW-1:0]  r_s6_p [2][EDGES][EDGES];
    logic signed [XW-1:0]  r_s6_q [2][EDGES][EDGES];
    // stage 7: result
    logic                  r_overlap;
    t_cause                r_cause;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 2; b++) begin
                r_s1_sin[b] <= trig_ref({1'b0, in_an[b]});
                r_s1_cos[b] <= trig_ref({1'b0, in_an[b]} + (ANG_BITS + 1)'(QUARTER));
                r_s1_cx[b]  <= in_cx[b];
                r_s1_cy[b]  <= in_cy[b];
                r_s1_dx[b]  <= in_dx[b];
                r_s1_dy[b]  <= in_dy[b];

                r_s2_sneg[b] <= r_s1_sin[b].neg;
                r_s2_cneg[b] <= r_s1_cos[b].neg;
                r_s2_cx[b]   <= r_s1_cx[b];
                r_s2_cy[b]   <= r_s1_cy[b];
                r_s2_dx[b]   <= r_s1_dx[b];
                r_s2_dy[b]   <= r_s1_dy[b];
            end
            r_s2_sin[0] <= mem0[r_s1_sin[0].idx];
            r_s2_cos[0] <= mem1[r_s1_cos[0].idx];
            r_s2_sin[1] <= mem2[r_s1_sin[1].idx];
            r_s2_cos[1] <= mem3[r_s1_cos[1].idx];
        end
    end

    // stage 3 products
    logic signed [TRIG_BITS:0]  s_val [2], c_val [2];
    logic signed [COORD_BITS:0] dx_s [2], dy_s [2];

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            s_val[b] = r_s2_sneg[b] ? -signed'({1'b0, r_s2_sin[b]}) : signed'({1'b0, r_s2_sin[b]});
            c_val[b] = r_s2_cneg[b] ? -signed'({1'b0, r_s2_cos[b]}) : signed'({1'b0, r_s2_cos[b]});
            dx_s[b]  = signed'({1'b0, r_s2_dx[b]});
            dy_s[b]  = signed'({1'b0, r_s2_dy[b]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 2; b++) begin
                r_s3_sdy[b] <= MW'(s_val[b] * dy_s[b]);
                r_s3_cdy[b] <= MW'(c_val[b] * dy_s[b]);
                r_s3_cdx[b] <= MW'(c_val[b] * dx_s[b]);
                r_s3_sdx[b] <= MW'(s_val[b] * dx_s[b]);
                r_s3_cx[b]  <= r_s2_cx[b];
                r_s3_cy[b]  <= r_s2_cy[b];
            end
        end
    end

    // stage 4: P0 = C + v, P1 = C + u, P2 = C - v, P3 = C - u
    logic signed [PW-1:0] cxs [2], cys [2];
    t_pt                  n_s4_p [2][EDGES];

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            cxs[b] = signed'(PW'({r_s3_cx[b], 15'd0}));
            cys[b] = signed'(PW'({r_s3_cy[b], 15'd0}));
            n_s4_p[b][0].x = cxs[b] - r_s3_cdx[b];
            n_s4_p[b][0].y = cys[b] - r_s3_sdx[b];
            n_s4_p[b][1].x = cxs[b] + r_s3_sdy[b];
            n_s4_p[b][1].y = cys[b] - r_s3_cdy[b];
            n_s4_p[b][2].x = cxs[b] + r_s3_cdx[b];
            n_s4_p[b][2].y = cys[b] + r_s3_sdx[b];
            n_s4_p[b][3].x = cxs[b] - r_s3_sdy[b];
            n_s4_p[b][3].y = cys[b] + r_s3_cdy[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en)
            r_s4_p <= n_s4_p;
    end

    // stage 5: differences; box b's corners tested against the other box's edges
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < EDGES; k++) begin
                    r_s5_ex[b][k] <= DW'(r_s4_p[b][(k + 1) % EDGES].x) - DW'(r_s4_p[b][k].x);
                    r_s5_ey[b][k] <= DW'(r_s4_p[b][(k + 1) % EDGES].y) - DW'(r_s4_p[b][k].y);
                    for (int i = 0; i < EDGES; i++) begin
                        r_s5_qx[b][i][k] <= DW'(r_s4_p[b][i].x) - DW'(r_s4_p[1 - b][k].x);
                        r_s5_qy[b][i][k] <= DW'(r_s4_p[b][i].y) - DW'(r_s4_p[1 - b][k].y);
                    end
                end
            end
        end
    end

    // stage 6: cross product halves
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 2; b++) begin
                for (int i = 0; i < EDGES; i++) begin
                    for (int k = 0; k < EDGES; k++) begin
                        r_s6_p[b][i][k] <= XW'(r_s5_ex[1 - b][k]) * XW'(r_s5_qy[b][i][k]);
                        r_s6_q[b][i][k] <= XW'(r_s5_ey[1 - b][k]) * XW'(r_s5_qx[b][i][k]);
                    end
                end
            end
        end
    end

    // stage 7: edge signs, counts and decision
    logic signed [XW:0] diff;
    logic [2:0]         npass [2][EDGES];
    logic               any_full [2];
    logic [3:0]         star;
    t_cause             n_cause;

    always_comb begin
        star = '0;
        for (int b = 0; b < 2; b++) begin
            any_full[b] = 1'b0;
            for (int i = 0; i < EDGES; i++) begin
                npass[b][i] = '0;
                for (int k = 0; k < EDGES; k++) begin
                    diff = (XW + 1)'(r_s6_p[b][i][k]) - (XW + 1)'(r_s6_q[b][i][k]);
                    if (!diff[XW])
                        npass[b][i] = npass[b][i] + 3'd1;
                end
                if (npass[b][i] == 3'(EDGES))
                    any_full[b] = 1'b1;
                if (npass[b][i] == 3'(STAR_TESTS))
                    star = star + 4'd1;
            end
        end
        if (any_full[0])
            n_cause = CAUSE_A_IN_B;
        else if (any_full[1])
            n_cause = CAUSE_B_IN_A;
        else if (star >= 4'(STAR_MIN))
            n_cause = CAUSE_STAR;
        else
            n_cause = CAUSE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cause   <= n_cause;
            r_overlap <= (n_cause != CAUSE_NONE);
        end
    end

    assign m_axis_tdata = {5'd0, r_cause, r_overlap};

endmodule

// ----- src/rbot_checker.sv -----
// port-level checks for the rotated box overlap test core
module rbot_checker import rbot_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OUT_BITS-1:0] m_axis_tdata
);

    // overlap flag agrees with cause
    a_flag_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != 2'd0)))
        else $error("overlap flag disagrees with cause");

    // pad bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0))
        else $error("output pad bits set");

    // table fill keeps input closed right after reset
    a_fill: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("ready or valid high right after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

endmodule

bind rotated_box_overlap_test_core rbot_checker u_rbot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
